// ----- rtl/core/hdes_pkg.sv -----
// Shared types and constants for the early-stop Hamming distance block.
package hdes_pkg;

   localparam int DIST_W     = 10;
   localparam int WDIST_W    = 5;
   localparam int BASE_W     = 8;
   localparam int WORD_BASES = 8;

   localparam logic [DIST_W-1:0] DIST_SAT   = 10'd1023;
   localparam logic [DIST_W-1:0] MAXD_RESET = 10'd512;

   localparam logic [BASE_W-1:0] CHAR_A = 8'h41;
   localparam logic [BASE_W-1:0] CHAR_C = 8'h43;
   localparam logic [BASE_W-1:0] CHAR_G = 8'h47;
   localparam logic [BASE_W-1:0] CHAR_T = 8'h54;

   typedef struct packed {
      logic [63:0] first_seq_bases;
      logic [63:0] second_seq_bases;
      logic [3:0]  valid_bases;
      logic        last_word;
   } hdes_req_type;

   typedef struct packed {
      logic [DIST_W-1:0] distance;
      logic              cut_short;
   } hdes_rsp_type;

   // one classified word waiting for the accumulator
   typedef struct packed {
      logic [WDIST_W-1:0] word_dist;
      logic               last;
   } hdes_entry_type;

   typedef struct packed {
      logic           valid;
      hdes_entry_type entry;
   } hdes_head_type;

endpackage

// ----- rtl/core/hdes_front.sv -----
// Front end: encodes the bases of one request and sums the per-base distance.
module hdes_front import hdes_pkg::*; (
   input  logic           req_valid,
   output logic           req_ready,
   input  hdes_req_type   req_data,
   input  logic           q_full,
   output logic           push,
   output hdes_entry_type push_entry
);

   function automatic logic [3:0] one_hot(input logic [BASE_W-1:0] ch);
      logic [3:0] code;
      code = 4'b0000;
      if (ch == CHAR_A) code = 4'b0001;
      if (ch == CHAR_C) code = 4'b0010;
      if (ch == CHAR_G) code = 4'b0100;
      if (ch == CHAR_T) code = 4'b1000;
      return code;
   endfunction

   logic [1:0]         base_dist [WORD_BASES];
   logic [WDIST_W-1:0] sum;

   always_comb begin
      for (int i = 0; i < WORD_BASES; i++) begin
         logic [3:0] ea;
         logic [3:0] eb;
         ea = one_hot(req_data.first_seq_bases[i*BASE_W +: BASE_W]);
         eb = one_hot(req_data.second_seq_bases[i*BASE_W +: BASE_W]);
         // bases past the valid count are blank in both sequences
         if (req_data.valid_bases <= 4'(i) || ea == eb) begin
            base_dist[i] = 2'd0;
         end else begin
            base_dist[i] = {1'b0, |ea} + {1'b0, |eb};
         end
      end
   end

   always_comb begin
      sum = '0;
      for (int i = 0; i < WORD_BASES; i++) begin
         sum = sum + WDIST_W'(base_dist[i]);
      end
   end

   assign req_ready            = !q_full;
   assign push                 = req_valid && !q_full;
   assign push_entry.word_dist = sum;
   assign push_entry.last      = req_data.last_word;

endmodule

// ----- rtl/core/hdes_queue.sv -----
// Short FIFO of classified words between the front end and the accumulator.
module hdes_queue import hdes_pkg::*; #(
   parameter int DEPTH = 4
) (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  hdes_entry_type push_entry,
   output logic           full,
   input  logic           pop,
   output hdes_head_type  head
);

   localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W = $clog2(DEPTH + 1);

   hdes_entry_type   mem [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;

   function automatic logic [PTR_W-1:0] ptr_next(input logic [PTR_W-1:0] p);
      return (p == PTR_W'(DEPTH - 1)) ? '0 : p + PTR_W'(1);
   endfunction

   always_comb begin
      wr_ptr_in = push ? ptr_next(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop  ? ptr_next(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff + CNT_W'(push) - CNT_W'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_entry;
      end
   end

   assign full       = (count_ff == CNT_W'(DEPTH));
   assign head.valid = (count_ff != '0);
   assign head.entry = mem[rd_ptr_ff];

`ifndef SYNTHESIS
   a_no_overflow: assert property (@(posedge clock) disable iff (reset)
      push |-> count_ff < CNT_W'(DEPTH))
      else $error("queue push while full");
   a_no_underflow: assert property (@(posedge clock) disable iff (reset)
      pop |-> count_ff != '0)
      else $error("queue pop while empty");
   a_count_track: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> count_ff == $past(count_ff) + CNT_W'(1))
      else $error("queue count lost a push");
`endif

endmodule

// ----- rtl/core/hdes_back.sv -----
// Back end: early-stop accumulator, limit register and result register.
module hdes_back import hdes_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [DIST_W-1:0] csr_data,
   input  hdes_head_type     head,
   output logic              pop,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hdes_rsp_type      rsp_data
);

   logic [DIST_W-1:0] max_ff;
   logic [DIST_W-1:0] run_ff, run_in;
   logic              skip_ff, skip_in;
   logic              rsp_valid_ff, rsp_valid_in;
   hdes_rsp_type      rsp_data_ff, rsp_data_in;
   logic [DIST_W-1:0] acc;
   logic              acc_skip;
   logic [DIST_W:0]   sum;
   logic              out_free;

   assign csr_ready = 1'b1;
   assign out_free  = !rsp_valid_ff || rsp_ready;
   // a last word needs the result register; others always drain
   assign pop       = head.valid && (!head.entry.last || out_free);

   always_comb begin
      sum = {1'b0, run_ff} + (DIST_W+1)'(head.entry.word_dist);
      if (run_ff >= max_ff) begin
         acc      = run_ff;
         acc_skip = 1'b1;
      end else begin
         acc      = (sum > {1'b0, DIST_SAT}) ? DIST_SAT : sum[DIST_W-1:0];
         acc_skip = skip_ff;
      end

      run_in       = run_ff;
      skip_in      = skip_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_data_in  = rsp_data_ff;
      if (pop) begin
         if (head.entry.last) begin
            run_in                = '0;
            skip_in               = 1'b0;
            rsp_valid_in          = 1'b1;
            rsp_data_in.distance  = acc;
            rsp_data_in.cut_short = acc_skip;
         end else begin
            run_in  = acc;
            skip_in = acc_skip;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         max_ff       <= MAXD_RESET;
         run_ff       <= '0;
         skip_ff      <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_valid) begin
            max_ff <= csr_data;
         end
         run_ff       <= run_in;
         skip_ff      <= skip_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_data_ff <= rsp_data_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_clear_on_last: assert property (@(posedge clock) disable iff (reset)
      (pop && head.entry.last) |=> (run_ff == '0 && !skip_ff && rsp_valid_ff))
      else $error("pair state not cleared after last word");
   a_run_monotonic: assert property (@(posedge clock) disable iff (reset)
      (pop && !head.entry.last) |=> run_ff >= $past(run_ff))
      else $error("running distance went down inside a pair");
   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_ready) |=> (rsp_valid_ff && $stable(rsp_data_ff)))
      else $error("pending result overwritten");
`endif

endmodule

// ----- rtl/core/dna_hamming_distance_early_stop.sv -----
// Top level of the streaming one-hot DNA Hamming distance with early stop.
//
//   channel | ports                          | moves
//   --------+--------------------------------+--------------------------------
//   req     | req_valid req_ready req_data   | one word of eight base pairs
//   rsp     | rsp_valid rsp_ready rsp_data   | distance and cut-short flag
//   csr     | csr_valid csr_ready csr_data   | max_distance write
//
// One request per cycle unless the queue is full; results are registered.
// The per-word sum is done at acceptance; the accumulator adds one queued word
// per cycle, and a last word waits in the queue only while the result
// register is still held by rsp_ready low. req_ready drops when the queue of
// QUEUE_DEPTH words is full. Synchronous reset clears the pair state and sets
// max_distance to 512.
module dna_hamming_distance_early_stop import hdes_pkg::*; #(
   parameter int QUEUE_DEPTH = 4
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  hdes_req_type      req_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output hdes_rsp_type      rsp_data,
   input  logic              csr_valid,
   output logic              csr_ready,
   input  logic [DIST_W-1:0] csr_data
);

   logic           q_full;
   logic           push;
   hdes_entry_type push_entry;
   logic           pop;
   hdes_head_type  head;

   hdes_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .q_full     (q_full),
      .push       (push),
      .push_entry (push_entry)
   );

   hdes_queue #(
      .DEPTH (QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (pop),
      .head       (head)
   );

   hdes_back u_back (
      .clock     (clock),
      .reset     (reset),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data),
      .head      (head),
      .pop       (pop),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data)
   );

endmodule

// ----- tb/dna_hamming_distance_early_stop_test.sv -----
// Testbench for the early-stop one-hot DNA Hamming distance block.
`timescale 1ns / 1ps

module dna_hamming_distance_early_stop_test;
   import hdes_pkg::*;

   typedef enum {
      IDLE_NONE,
      IDLE_SEND,
      IDLE_RECV,
      IDLE_BOTH
   } idle_mode_type;

   localparam logic [BASE_W-1:0] CHAR_N = 8'h4E;
   localparam int RANDOM_PHASES   = 8;
   localparam int WORDS_PER_PHASE = 172;
   // queue depth plus pipeline latency, with margin
   localparam int SETTLE_CYCLES   = 16;
   localparam int CFG_RANDOM      = -1;

   logic              clock;
   logic              reset      = 1'b1;
   logic              req_valid  = 1'b0;
   logic              req_ready;
   hdes_req_type      req_data   = '0;
   logic              rsp_valid;
   logic              rsp_ready  = 1'b0;
   hdes_rsp_type      rsp_data;
   logic              csr_valid  = 1'b0;
   logic              csr_ready;
   logic [DIST_W-1:0] csr_data   = '0;

   hdes_req_type word_queue[$];
   hdes_rsp_type predicted_distances[$];

   // shadow of the block's pair state and register
   logic [DIST_W-1:0] max_distance_cfg = MAXD_RESET;
   logic [DIST_W-1:0] pair_distance    = '0;
   logic              pair_skipped     = 1'b0;

   int unsigned send_idle_pct  = 0;
   int unsigned recv_stall_pct = 0;
   int unsigned fail_count     = 0;

   dna_hamming_distance_early_stop dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_data  (csr_data)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("FAIL");
      $finish;
   end

   function automatic logic [3:0] encode_base(input logic [BASE_W-1:0] ch);
      case (ch)
         CHAR_A:  return 4'b0001;
         CHAR_C:  return 4'b0010;
         CHAR_G:  return 4'b0100;
         CHAR_T:  return 4'b1000;
         default: return 4'b0000;
      endcase
   endfunction

   function automatic int unsigned word_mismatch(input hdes_req_type w);
      int unsigned count;
      int unsigned sum;
      count = (w.valid_bases > WORD_BASES) ? WORD_BASES : w.valid_bases;
      sum = 0;
      for (int i = 0; i < count; i++)
         sum += $countones(encode_base(w.first_seq_bases[8*i +: 8]) ^
                           encode_base(w.second_seq_bases[8*i +: 8]));
      return sum;
   endfunction

   function automatic void accumulate_word(input hdes_req_type w);
      int unsigned sum;
      hdes_rsp_type result;
      if (pair_distance >= max_distance_cfg) begin
         pair_skipped = 1'b1;
      end else begin
         sum = pair_distance + word_mismatch(w);
         pair_distance = (sum > DIST_SAT) ? DIST_SAT : DIST_W'(sum);
      end
      if (w.last_word) begin
         result.distance  = pair_distance;
         result.cut_short = pair_skipped;
         predicted_distances.push_back(result);
         pair_distance = '0;
         pair_skipped  = 1'b0;
      end
   endfunction

   // request driver
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else begin
         if (req_valid && req_ready)
            accumulate_word(req_data);
         if (!req_valid || req_ready) begin
            if (word_queue.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
               req_data  <= word_queue.pop_front();
               req_valid <= 1'b1;
            end else begin
               req_valid <= 1'b0;
            end
         end
      end
   end

   always @(posedge clock) begin
      if (reset)
         rsp_ready <= 1'b0;
      else
         rsp_ready <= ($urandom_range(99) >= recv_stall_pct);
   end

   // result monitor
   always @(posedge clock) begin : result_check
      hdes_rsp_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (predicted_distances.size() == 0) begin
            $error("unexpected result: distance %0d cut_short %0b",
                   rsp_data.distance, rsp_data.cut_short);
            fail_count++;
         end else begin
            want = predicted_distances.pop_front();
            if (rsp_data.distance !== want.distance) begin
               $error("distance mismatch: expected %0d, actual %0d",
                      want.distance, rsp_data.distance);
               fail_count++;
            end
            if (rsp_data.cut_short !== want.cut_short) begin
               $error("cut_short mismatch: expected %0b, actual %0b",
                      want.cut_short, rsp_data.cut_short);
               fail_count++;
            end
         end
      end
   end

   function automatic void set_idling(input idle_mode_type mode);
      send_idle_pct  = (mode == IDLE_SEND) ? 64 : (mode == IDLE_BOTH) ? 19 : 0;
      recv_stall_pct = (mode == IDLE_RECV) ? 64 : (mode == IDLE_BOTH) ? 19 : 0;
   endfunction

   function automatic logic [63:0] pack_bases(input string s);
      logic [63:0] w;
      w = '0;
      for (int i = 0; i < s.len() && i < 8; i++)
         w[8*i +: 8] = s[i];
      return w;
   endfunction

   function automatic void queue_word(input logic [63:0] first, input logic [63:0] second,
                                      input logic [3:0] valid, input logic last);
      hdes_req_type w;
      w.first_seq_bases  = first;
      w.second_seq_bases = second;
      w.valid_bases      = valid;
      w.last_word        = last;
      word_queue.push_back(w);
   endfunction

   function automatic logic [BASE_W-1:0] random_base();
      int unsigned pick;
      pick = $urandom_range(99);
      if (pick < 85) begin
         case ($urandom_range(3))
            0:       return CHAR_A;
            1:       return CHAR_C;
            2:       return CHAR_G;
            default: return CHAR_T;
         endcase
      end
      if (pick < 92)
         return CHAR_N;
      return BASE_W'($urandom_range(255));
   endfunction

   // one sequence pair; a few long, highly divergent pairs reach the cutoff
   function automatic int unsigned queue_random_pair();
      int unsigned words;
      int unsigned mis_pct;
      int unsigned shape;
      logic [BASE_W-1:0] ca;
      hdes_req_type w;
      shape = $urandom_range(99);
      if (shape < 10) begin
         words   = $urandom_range(45, 30);
         mis_pct = $urandom_range(100, 70);
      end else if (shape < 45) begin
         words   = $urandom_range(8, 2);
         mis_pct = $urandom_range(100);
      end else begin
         words   = 1;
         mis_pct = $urandom_range(100);
      end
      for (int n = 0; n < words; n++) begin
         for (int i = 0; i < 8; i++) begin
            ca = random_base();
            w.first_seq_bases[8*i +: 8]  = ca;
            w.second_seq_bases[8*i +: 8] = ($urandom_range(99) < mis_pct) ? random_base() : ca;
         end
         if ($urandom_range(99) < 4) begin
            w.first_seq_bases  = {$urandom, $urandom};
            w.second_seq_bases = {$urandom, $urandom};
         end
         shape = $urandom_range(99);
         if (shape < 8)
            w.valid_bases = 4'($urandom_range(15));
         else if (n == words - 1)
            w.valid_bases = 4'($urandom_range(8, 1));
         else
            w.valid_bases = 4'(WORD_BASES);
         w.last_word = (n == words - 1);
         word_queue.push_back(w);
      end
      return words;
   endfunction

   // idle only once every request went in and every result came out
   task automatic wait_drained();
      do
         @(posedge clock);
      while (word_queue.size() != 0 || req_valid || predicted_distances.size() != 0);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_max_distance(input logic [DIST_W-1:0] value);
      csr_valid <= 1'b1;
      csr_data  <= value;
      do
         @(posedge clock);
      while (!csr_ready);
      csr_valid        <= 1'b0;
      max_distance_cfg  = value;
   endtask

   initial begin : stimulus
      int phase_cfg[RANDOM_PHASES];
      idle_mode_type phase_idle[RANDOM_PHASES];
      int unsigned queued;
      phase_cfg  = '{512, 1, 40, CFG_RANDOM, 0, 512, CFG_RANDOM, 100};
      phase_idle = '{IDLE_NONE, IDLE_SEND, IDLE_RECV, IDLE_BOTH,
                     IDLE_SEND, IDLE_BOTH, IDLE_RECV, IDLE_NONE};

      repeat (10) @(posedge clock);
      reset <= 1'b0;
      set_idling(IDLE_NONE);

      // single-word pairs at the reset maximum
      queue_word(pack_bases("AAAAAAAA"), pack_bases("AAAAAAAA"), 8, 1'b1);
      queue_word(pack_bases("ACGTACGT"), pack_bases("CGTACGTA"), 8, 1'b1);
      queue_word(pack_bases("ACGTACGT"), pack_bases("NNNNNNNN"), 8, 1'b1);
      queue_word(pack_bases("ACGT"), pack_bases("acgt"), 4, 1'b1);
      queue_word({64{1'b1}}, '0, 8, 1'b1);
      queue_word(pack_bases("AAAAAAAA"), pack_bases("CCCCCCCC"), 1, 1'b1);
      queue_word(pack_bases("AAAAAAAA"), pack_bases("TTTTTTTT"), 0, 1'b1);
      queue_word(pack_bases("AAAAAAAA"), pack_bases("GGGGGGGG"), 15, 1'b1);
      queue_word(pack_bases("ACGTACGT"), pack_bases("TTTTTTTT"), 9, 1'b1);
      // multi-word pair
      queue_word(pack_bases("CCCCCCCC"), pack_bases("GGGGGGGG"), 8, 1'b0);
      queue_word(pack_bases("ACGTACGT"), pack_bases("ACGTACGT"), 8, 1'b0);
      queue_word(pack_bases("AC"), pack_bases("AG"), 2, 1'b1);
      queue_word({$urandom, $urandom}, {$urandom, $urandom}, 8, 1'b1);
      wait_drained();

      // cutoff reached mid-pair, exactly at the limit, and on a zero-count word
      write_max_distance(10'd20);
      queue_word(pack_bases("AAAAAAAA"), pack_bases("CCCCCCCC"), 8, 1'b0);
      queue_word(pack_bases("AAAAAAAA"), pack_bases("CCCCCCCC"), 8, 1'b0);
      queue_word(pack_bases("AAAAAAAA"), pack_bases("CCCCCCCC"), 8, 1'b0);
      queue_word(pack_bases("AAAAAAAA"), pack_bases("CCCCCCCC"), 8, 1'b1);
      queue_word(pack_bases("AAAAA"), pack_bases("CCCCC"), 5, 1'b0);
      queue_word(pack_bases("AAAAA"), pack_bases("CCCCC"), 5, 1'b1);
      queue_word(pack_bases("AAAAA"), pack_bases("CCCCC"), 5, 1'b0);
      queue_word(pack_bases("AAAAA"), pack_bases("CCCCC"), 5, 1'b0);
      queue_word(pack_bases("A"), pack_bases("C"), 0, 1'b1);
      wait_drained();

      // zero maximum skips everything
      write_max_distance('0);
      queue_word(pack_bases("AAAAAAAA"), pack_bases("CCCCCCCC"), 8, 1'b1);
      queue_word(pack_bases("GGGGGGGG"), pack_bases("TTTTTTTT"), 8, 1'b0);
      queue_word(pack_bases("GGGGGGGG"), pack_bases("TTTTTTTT"), 8, 1'b1);
      wait_drained();

      for (int p = 0; p < RANDOM_PHASES; p++) begin
         if (phase_cfg[p] == CFG_RANDOM)
            write_max_distance(DIST_W'($urandom_range(512)));
         else
            write_max_distance(DIST_W'(phase_cfg[p]));
         set_idling(phase_idle[p]);
         queued = 0;
         while (queued < WORDS_PER_PHASE)
            queued += queue_random_pair();
         wait_drained();
      end

      if (fail_count == 0)
         $display("PASS");
      else
         $display("FAIL");
      $finish;
   end

endmodule

// ----- filelist.f -----
rtl/core/hdes_pkg.sv
rtl/core/hdes_front.sv
rtl/core/hdes_queue.sv
rtl/core/hdes_back.sv
rtl/core/dna_hamming_distance_early_stop.sv
tb/dna_hamming_distance_early_stop_test.sv
